// File: src/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and codes for the palette count table: channel items,
// operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  // Width of palette indices, histogram positions and the fill count
  localparam int IDX_W = 6;

  // Operation codes
  localparam logic [1:0] FN_INTEGRATE = 2'd0;
  localparam logic [1:0] FN_LOOKUP    = 2'd1;
  localparam logic [1:0] FN_FETCH     = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [31:0] key_value;
    logic [IDX_W-1:0]  symbol_index;
    logic [31:0]       escape_count;
  } pct_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   found_index;
    logic [IDX_W-1:0]   hist_position;
    logic [31:0]        hist_value;
    logic signed [31:0] value_out;
    logic               last;
  } pct_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EMIT
  } pct_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic emit;
  } pct_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_func;
    logic [1:0] func;
    logic       match;
    logic       scan_end;
    logic       out_free;
    logic       last_elem;
  } pct_stat_t;

endpackage

`default_nettype wire

// File: src/pct_if.sv
// ----------------------------------------------------------------------------
// pct_if
// Valid/ready channels for the palette count table: one for operations in,
// one for result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pct_in_if import pct_pkg::*; ();
  logic    valid;
  logic    ready;
  pct_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pct_out_if import pct_pkg::*; ();
  logic     valid;
  logic     ready;
  pct_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/pct_ram.sv
// ----------------------------------------------------------------------------
// pct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer for the palette count table: accept an operation, scan the
// palette, read entries and emit result transfers one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_ctrl import pct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pct_stat_t stat,
  output pct_cmd_t       cmd
);

  pct_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (stat.in_func)
            FN_INTEGRATE: state_next = S_SCAN;
            FN_LOOKUP:    state_next = S_SCAN;
            FN_FETCH:     state_next = S_READ;
            default:      state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.match || stat.scan_end) begin
          state_next = (stat.func == FN_INTEGRATE) ? S_EMIT : S_READ;
        end
      end
      S_READ: state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.last_elem ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    cmd.start = (state == S_IDLE) && in_valid;
    cmd.scan  = (state == S_SCAN);
    cmd.emit  = (state == S_EMIT) && stat.out_free;
  end

endmodule

`default_nettype wire

// File: src/pct_datapath.sv
// ----------------------------------------------------------------------------
// pct_datapath
// Palette storage as a ring in two RAMs (values and counts) with a head
// pointer at the newest entry, operand registers, scan pipeline, result
// formatting and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_datapath import pct_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire pct_in_t in_data,
  input  wire pct_cmd_t cmd,
  output pct_stat_t    stat,
  pct_out_if.source    results
);

  localparam int PHYS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = IDX_W + 1;

  // Control state
  logic [PHYS_W-1:0] head;
  logic [IDX_W-1:0]  used;
  logic              out_valid;
  logic              chk_valid;

  // Operand and scan registers
  logic [1:0]            op_func;
  logic [VALUE_BITS-1:0] op_key;
  logic [IDX_W-1:0]      op_sym;
  logic [31:0]           op_esc;
  logic [IDX_W-1:0]      pos;
  logic [IDX_W-1:0]      chk_pos;
  logic [PHYS_W-1:0]     chk_phys;
  logic [IDX_W-1:0]      found_idx;
  logic [PHYS_W-1:0]     found_phys;
  logic [COUNT_BITS-1:0] found_hit;
  logic [IDX_W-1:0]      hpos;
  pct_out_t              out_data;

  logic [63:0]           key_sx;
  logic [IDX_W-1:0]      rd_off;
  logic [SUM_W-1:0]      rd_sum;
  logic [SUM_W-1:0]      rd_wrap;
  logic [PHYS_W-1:0]     rd_phys;
  logic [PHYS_W-1:0]     head_dec;
  logic [VALUE_BITS-1:0] val_rd;
  logic [COUNT_BITS-1:0] hit_rd;
  logic [COUNT_BITS-1:0] hit_sat;
  logic [63:0]           hit_sat64;
  logic [63:0]           hit_rd64;
  logic [63:0]           val_rd64;
  logic                  is_full;
  logic                  do_insert;
  logic                  do_hit;
  logic                  fetch_ok;
  logic                  match;
  logic                  hit_we;
  logic [PHYS_W-1:0]     hit_waddr;
  logic [COUNT_BITS-1:0] hit_wdata;
  pct_out_t              res;

  // Sign-extend the key, then keep the stored width
  assign key_sx = {{32{in_data.key_value[31]}}, in_data.key_value};

  // Logical offset to physical ring slot
  always_comb begin
    if (cmd.scan) begin
      rd_off = pos;
    end else if (op_func == FN_FETCH) begin
      rd_off = op_sym - IDX_W'(1);
    end else begin
      rd_off = hpos - IDX_W'(2);
    end
    rd_sum  = SUM_W'(head) + SUM_W'(rd_off);
    rd_wrap = (rd_sum >= SUM_W'(DEPTH)) ? rd_sum - SUM_W'(DEPTH) : rd_sum;
    rd_phys = rd_wrap[PHYS_W-1:0];
  end

  assign head_dec = (head == '0) ? PHYS_W'(DEPTH - 1) : head - PHYS_W'(1);

  // Count update and width conversions
  assign hit_sat   = (&found_hit) ? found_hit : found_hit + COUNT_BITS'(1);
  assign hit_sat64 = 64'(hit_sat);
  assign hit_rd64  = 64'(hit_rd);
  assign val_rd64  = 64'(val_rd);

  assign is_full   = (used >= IDX_W'(DEPTH));
  assign match     = chk_valid && (val_rd == op_key);
  assign fetch_ok  = (op_sym != '0) && (op_sym <= used);
  assign do_hit    = cmd.emit && (op_func == FN_INTEGRATE) && (found_idx != '0);
  assign do_insert = cmd.emit && (op_func == FN_INTEGRATE) && (found_idx == '0) && !is_full;

  // Count RAM write: bump on a hit, seed on an insert
  always_comb begin
    hit_we    = do_hit || do_insert;
    hit_waddr = do_hit ? found_phys : head_dec;
    hit_wdata = do_hit ? hit_sat : COUNT_BITS'(1);
  end

  pct_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH), .AW(PHYS_W)) u_values (
    .clk   (clk),
    .we    (do_insert),
    .waddr (head_dec),
    .wdata (op_key),
    .raddr (rd_phys),
    .rdata (val_rd)
  );

  pct_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH), .AW(PHYS_W)) u_hits (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (rd_phys),
    .rdata (hit_rd)
  );

  // Palette bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      used <= '0;
    end else if (do_insert) begin
      head <= head_dec;
      used <= used + IDX_W'(1);
    end
  end

  // Latch the operation and walk the scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.start) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid <= (pos < used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_idx <= '0;
    end else if (cmd.start) begin
      op_func   <= in_data.func;
      op_key    <= key_sx[VALUE_BITS-1:0];
      op_sym    <= in_data.symbol_index;
      op_esc    <= in_data.escape_count;
      pos       <= '0;
      found_idx <= '0;
      hpos      <= '0;
    end else begin
      if (cmd.scan) begin
        if (pos < used) begin
          pos <= pos + IDX_W'(1);
        end
        chk_pos  <= pos;
        chk_phys <= rd_phys;
        if (match) begin
          found_idx  <= chk_pos + IDX_W'(1);
          found_phys <= chk_phys;
          found_hit  <= hit_rd;
        end
      end
      if (cmd.emit) begin
        hpos <= hpos + IDX_W'(1);
      end
    end
  end

  // Format the result for the current step
  always_comb begin
    res = '0;
    res.last = 1'b1;
    case (op_func)
      FN_INTEGRATE: begin
        if (found_idx != '0) begin
          res.status      = ST_OK;
          res.found_index = found_idx;
          res.hist_value  = hit_sat64[31:0];
        end else if (is_full) begin
          res.status = ST_FULL;
        end else begin
          res.status      = ST_OK;
          res.found_index = IDX_W'(1);
          res.hist_value  = 32'd1;
        end
      end
      FN_LOOKUP: begin
        res.status        = (found_idx != '0) ? ST_OK : ST_MISS;
        res.found_index   = found_idx;
        res.hist_position = hpos;
        if (hpos == '0) begin
          res.hist_value = '0;
        end else if (hpos == IDX_W'(1)) begin
          res.hist_value = op_esc;
        end else begin
          res.hist_value = hit_rd64[31:0];
        end
        res.last = (hpos == used + IDX_W'(1));
      end
      FN_FETCH: begin
        res.status    = fetch_ok ? ST_OK : ST_MISS;
        res.value_out = fetch_ok ? val_rd64[31:0] : '0;
      end
      default: res.status = ST_MISS;
    endcase
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Status to the controller
  always_comb begin
    stat.in_func   = in_data.func;
    stat.func      = op_func;
    stat.match     = match;
    stat.scan_end  = !chk_valid && (pos >= used);
    stat.out_free  = !out_valid || results.ready;
    stat.last_elem = (op_func != FN_LOOKUP) || (hpos == used + IDX_W'(1));
  end

  // Fill count never passes the palette size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= IDX_W'(DEPTH))
    else $error("fill count above palette size");

  // A recorded match lies inside the filled part of the palette
  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    found_idx <= used)
    else $error("found index beyond fill count");

  // An insert grows the palette by exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (used == $past(used) + IDX_W'(1)))
    else $error("insert did not grow the palette");

  // A result is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !cmd.emit)
    else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire

// File: src/palette_count_table.sv
// Sequence after accept: fetch reads the entry, then emits; an unused code emits at once;
// integrate scans until a match or the end of the stored entries, then emits; lookup
// scans the same way, then reads and emits each element in turn (fill count + 2 elements).
// The scan reads one stored entry per cycle; a stalled result holds the sequencer.
// Throughput: one operation at a time; the next is taken once the last result is loaded.
// Reset clears the fill count and head pointer; palette RAMs are not cleared.
// ----------------------------------------------------------------------------
// palette_count_table
// Adaptive palette of distinct pixel values with saturating occurrence
// counts: integrate, lookup with histogram stream, and fetch by index.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_count_table import pct_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  pct_in_if.sink    items,
  pct_out_if.source results
);

  pct_cmd_t  cmd;
  pct_stat_t stat;
  logic      ready;

  assign items.ready = ready;

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pct_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_data (items.data),
    .cmd     (cmd),
    .stat    (stat),
    .results (results)
  );

endmodule

`default_nettype wire
